FILE: src/cse_pkg.sv
// ---------------------------------------------------------------------------
// cse_pkg
// shared types and constants for the curve spline evaluator
// ---------------------------------------------------------------------------
package cse_pkg;

	localparam int MaxPoints = 16;
	localparam int FracBits  = 16;
	localparam int IdxW      = 4;
	localparam int CoordW    = 16;
	localparam int UW        = FracBits + 1;
	localparam int StepW     = 5;

	localparam logic CfgSmoothMode = 1'b0;
	localparam logic CfgPointCount = 1'b1;

	localparam logic OpWrite = 1'b0;
	localparam logic OpEval  = 1'b1;

	// token travelling down the row of cells during a segment search
	typedef struct packed {
		logic              live;
		logic              found;
		logic [IdxW-1:0]   seg;
		logic [CoordW-1:0] pos;
	} search_t;

	typedef logic [CoordW-1:0] coord_t;

endpackage

FILE: src/cse_cell.sv
// ---------------------------------------------------------------------------
// cse_cell
// one control point slot; checks the search token against its segment
// ---------------------------------------------------------------------------
module cse_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [cse_pkg::IdxW-1:0] slot,
	input  logic                   wr_en,
	input  cse_pkg::coord_t        wr_x,
	input  cse_pkg::coord_t        wr_y,
	input  cse_pkg::coord_t        reset_xy,
	input  cse_pkg::coord_t        next_x,
	input  logic                   in_range,
	input  cse_pkg::search_t       tok_in,
	output cse_pkg::search_t       tok_out,
	output cse_pkg::coord_t        x,
	output cse_pkg::coord_t        y
);
	import cse_pkg::*;

	coord_t  x_q, y_q;
	search_t tok_q, tok_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= reset_xy;
			y_q <= reset_xy;
		end else if (wr_en) begin
			x_q <= wr_x;
			y_q <= wr_y;
		end
	end

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.live && !tok_in.found && in_range &&
		    tok_in.pos >= x_q && tok_in.pos <= next_x) begin
			tok_nxt.found = 1'b1;
			tok_nxt.seg   = slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;
	assign x = x_q;
	assign y = y_q;
endmodule

FILE: src/cse_math.sv
// ---------------------------------------------------------------------------
// cse_math
// restoring divider for u and the linear or cubic evaluation sequencer
// ---------------------------------------------------------------------------
module cse_math (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            smooth,
	input  logic            direct,
	input  cse_pkg::coord_t direct_val,
	input  cse_pkg::coord_t pos,
	input  cse_pkg::coord_t x1,
	input  cse_pkg::coord_t x2,
	input  cse_pkg::coord_t p0,
	input  cse_pkg::coord_t p1,
	input  cse_pkg::coord_t p2,
	input  cse_pkg::coord_t p3,
	output logic            done,
	output cse_pkg::coord_t result
);
	import cse_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_MUL  = 5'b00100,
		S_ADD  = 5'b01000,
		S_DONE = 5'b10000
	} mstate_t;

	mstate_t            st_q;
	logic [StepW-1:0]   step_q;
	logic [CoordW:0]    rem_q;
	logic [CoordW-1:0]  num_q, den_q;
	logic [UW-1:0]      u_q;
	logic               smooth_q;
	logic signed [19:0] a_q, b_q, c_q, acc_q;
	logic signed [38:0] prod_q;
	logic [1:0]         hstep_q;
	coord_t             y1_q, y2_q, res_q;
	logic               done_q;

	logic [CoordW+1:0]  rem_sh;
	logic [UW-1:0]      u_sat;
	logic signed [38:0] p_mul;
	logic signed [21:0] fl;
	logic signed [21:0] nxt;
	logic [33:0]        lin;

	assign rem_sh = {rem_q, num_q[CoordW-1]};
	assign u_sat  = (u_q > UW'(1 << FracBits)) ? UW'(1 << FracBits) : u_q;
	assign p_mul  = 39'(acc_q) * $signed({1'b0, u_sat});
	assign fl     = 22'(prod_q >>> FracBits);
	always_comb begin
		nxt = '0;
		case (hstep_q)
			2'd0:    nxt = fl + 22'(c_q);
			2'd1:    nxt = fl + 22'(b_q);
			default: nxt = fl + 22'(a_q);
		endcase
	end
	assign lin = 34'(y1_q) * 34'((UW)'(1 << FracBits) - u_sat)
	           + 34'(y2_q) * 34'(u_sat) + 34'(1 << (FracBits - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == S_DONE);
			case (st_q)
				S_IDLE: if (start) begin
					smooth_q <= smooth;
					y1_q <= p1;
					y2_q <= p2;
					a_q  <= 20'(2 * $signed({4'b0, p1}));
					b_q  <= 20'($signed({4'b0, p2}) - $signed({4'b0, p0}));
					c_q  <= 20'(2 * $signed({4'b0, p0}) - 5 * $signed({4'b0, p1})
					        + 4 * $signed({4'b0, p2}) - $signed({4'b0, p3}));
					acc_q <= 20'(-$signed({4'b0, p0}) + 3 * $signed({4'b0, p1})
					        - 3 * $signed({4'b0, p2}) + $signed({4'b0, p3}));
					num_q <= pos - x1;
					den_q <= x2 - x1;
					rem_q <= '0;
					u_q   <= '0;
					step_q <= '0;
					hstep_q <= '0;
					if (direct) begin
						res_q <= direct_val;
						st_q  <= S_DONE;
					end else begin
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					// one quotient bit a cycle over numerator << FracBits
					if (den_q == '0) begin
						u_q  <= '0;
						st_q <= S_MUL;
					end else begin
						if (rem_sh >= {1'b0, den_q}) begin
							rem_q <= (CoordW+1)'(rem_sh - {1'b0, den_q});
							u_q   <= {u_q[UW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh[CoordW:0];
							u_q   <= {u_q[UW-2:0], 1'b0};
						end
						num_q  <= {num_q[CoordW-2:0], 1'b0};
						step_q <= step_q + 1'b1;
						if (step_q == StepW'(CoordW + FracBits - 1)) st_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (!smooth_q) begin
						res_q <= lin[FracBits +: CoordW];
						st_q  <= S_DONE;
					end else begin
						prod_q <= p_mul;
						st_q   <= S_ADD;
					end
				end
				S_ADD: begin
					acc_q <= 20'(nxt);
					if (hstep_q == 2'd2) begin
						if (nxt <= 0)                res_q <= '0;
						else if (nxt >= 22'sd131070) res_q <= 16'hFFFF;
						else                         res_q <= CoordW'((nxt + 1) >>> 1);
						st_q <= S_DONE;
					end else begin
						hstep_q <= hstep_q + 1'b1;
						st_q    <= S_MUL;
					end
				end
				S_DONE: begin
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;
endmodule

FILE: src/curve_spline_evaluator_top.sv
// ---------------------------------------------------------------------------
// curve_spline_evaluator_top
// piecewise linear or catmull-rom transfer curve over a 16-point table
// ---------------------------------------------------------------------------
// write items: accepted while idle, no result item
// evaluate items: one result item each, after a 16-cell search, a 32-step divider,
//   then one blend step (linear) or three multiply-add steps (cubic)
// at or beyond an end point or with no segment the arithmetic is bypassed; on a zero-width one the divider is skipped
// one item in flight, next one taken the cycle after its result is loaded; a held result stalls only the next
// reset: slot 0 = (0,0), slot 1 = (FFFF,FFFF), others zero; linear mode, 2 points
module curve_spline_evaluator_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [3:0]        point_index,
	input  logic [15:0]       point_x,
	input  logic [15:0]       point_y,
	input  logic [15:0]       position,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       curve_value,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [4:0]        cfg_data
);
	import cse_pkg::*;

	typedef enum logic [3:0] {
		T_IDLE   = 4'b0001,
		T_SEARCH = 4'b0010,
		T_MATH   = 4'b0100,
		T_OUT    = 4'b1000
	} tstate_t;

	tstate_t          st_q;
	logic             smooth_q;
	logic [IdxW-1:0]  last_q;
	coord_t           pos_q, out_q;
	logic             out_valid_q;

	coord_t  xs [MaxPoints];
	coord_t  ys [MaxPoints];
	search_t tok [MaxPoints+1];

	logic in_acc, eval_acc;
	logic direct;
	coord_t direct_val;
	search_t res_tok;
	logic [IdxW-1:0] seg, i0, i3;
	logic mstart, mdone;
	coord_t mres;
	logic out_load;

	assign in_ready  = (st_q == T_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign eval_acc  = in_acc && op == OpEval;

	// configuration registers; point count clamped into range on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= 1'b0;
			last_q   <= IdxW'(1);
		end else if (cfg_valid) begin
			if (cfg_index == CfgSmoothMode) smooth_q <= cfg_data[0];
			else begin
				if (cfg_data < 5'd2)       last_q <= IdxW'(1);
				else if (cfg_data > 5'd16) last_q <= IdxW'(MaxPoints - 1);
				else                       last_q <= IdxW'(cfg_data - 5'd1);
			end
		end
	end

	assign tok[0] = '{live: eval_acc, found: 1'b0, seg: '0, pos: position};

	// row of cells; each hands the search token to its neighbour every cycle
	for (genvar g = 0; g < MaxPoints; g++) begin : g_cell
		cse_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot     (IdxW'(g)),
			.wr_en    (in_acc && op == OpWrite && point_index == IdxW'(g)),
			.wr_x     (point_x),
			.wr_y     (point_y),
			.reset_xy ((g == 1) ? 16'hFFFF : 16'h0000),
			.next_x   (xs[(g + 1) % MaxPoints]),
			.in_range (IdxW'(g) < last_q && g < MaxPoints - 1),
			.tok_in   (tok[g]),
			.tok_out  (tok[g+1]),
			.x        (xs[g]),
			.y        (ys[g])
		);
	end

	assign res_tok = tok[MaxPoints];
	assign seg = res_tok.seg;
	assign i0  = (seg == '0) ? '0 : seg - 1'b1;
	assign i3  = (seg + IdxW'(2) < last_q && seg < IdxW'(MaxPoints - 2))
	             ? seg + IdxW'(2) : last_q;

	// end points and the no-segment case bypass the arithmetic
	always_comb begin
		direct = 1'b1;
		if (pos_q <= xs[0])           direct_val = ys[0];
		else if (pos_q >= xs[last_q]) direct_val = ys[last_q];
		else if (!res_tok.found)      direct_val = smooth_q ? ys[last_q] : '0;
		else begin
			direct     = 1'b0;
			direct_val = '0;
		end
	end

	assign mstart = (st_q == T_SEARCH) && res_tok.live;

	cse_math u_math (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (mstart),
		.smooth     (smooth_q),
		.direct     (direct),
		.direct_val (direct_val),
		.pos        (pos_q),
		.x1         (xs[seg]),
		.x2         (xs[seg + 1'b1]),
		.p0         (ys[i0]),
		.p1         (ys[seg]),
		.p2         (ys[seg + 1'b1]),
		.p3         (ys[i3]),
		.done       (mdone),
		.result     (mres)
	);

	// the output register takes a new result once the previous one has gone;
	// the math result holds until the next start, so it can wait in T_OUT
	assign out_load = ((st_q == T_MATH) && mdone && (!out_valid_q || out_ready)) ||
	                  ((st_q == T_OUT) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (out_load) out_q <= mres;
			case (st_q)
				T_IDLE: if (eval_acc) begin
					pos_q <= position;
					st_q  <= T_SEARCH;
				end
				T_SEARCH: if (mstart) st_q <= T_MATH;
				T_MATH: if (mdone) st_q <= out_load ? T_IDLE : T_OUT;
				T_OUT: if (out_load) st_q <= T_IDLE;
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign curve_value = out_q;
endmodule

FILE: tb/curve_spline_evaluator_top_tb.sv
// ---------------------------------------------------------------------------
// curve_spline_evaluator_top_tb
// checks point writes and curve evaluation in linear and catmull-rom modes
// against a cycle-free predictor. Stimulus is a short directed part and then
// random phases of mostly sorted tables with random content, under random
// idling and stalls on both channels.
// ---------------------------------------------------------------------------
module curve_spline_evaluator_top_tb;
	import cse_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// keeps its own copy of the table and registers, holds expected curve values
	class curve_scoreboard;
		coord_t    tab_x [MaxPoints];
		coord_t    tab_y [MaxPoints];
		bit        smooth;
		bit [4:0]  count;
		coord_t    expected_values [$];
		int        errors;

		function void clear();
			foreach (tab_x[i]) begin
				tab_x[i] = '0;
				tab_y[i] = '0;
			end
			tab_x[1] = 16'hFFFF;
			tab_y[1] = 16'hFFFF;
			smooth = 1'b0;
			count = 5'd2;
			errors = 0;
		endfunction

		function void set_register(logic idx, bit [4:0] data);
			if (idx == CfgSmoothMode)
				smooth = data[0];
			else
				count = data;
		endfunction

		function coord_t curve_at(coord_t t);
			int n, seg, i0, i3;
			longint one, u, x1, x2, p0, p1, p2, p3, acc, yv;
			n = count < 2 ? 2 : (count > MaxPoints ? MaxPoints : int'(count));
			one = longint'(1) << FracBits;
			u = 0;
			seg = -1;
			if (t <= tab_x[0])
				return tab_y[0];
			if (t >= tab_x[n-1])
				return tab_y[n-1];
			for (int i = 0; i < n - 1; i++) begin
				if (t >= tab_x[i] && t <= tab_x[i+1]) begin
					seg = i;
					break;
				end
			end
			if (seg < 0)
				return smooth ? tab_y[n-1] : coord_t'(0);
			x1 = tab_x[seg];
			x2 = tab_x[seg+1];
			if (x2 > x1)
				u = ((longint'(t) - x1) << FracBits) / (x2 - x1);
			if (u > one)
				u = one;
			if (!smooth) begin
				yv = (longint'(tab_y[seg]) * (one - u) + longint'(tab_y[seg+1]) * u
					+ (one >> 1)) >> FracBits;
				return coord_t'(yv);
			end
			i0 = seg > 0 ? seg - 1 : 0;
			i3 = seg + 2 < n - 1 ? seg + 2 : n - 1;
			p0 = tab_y[i0];
			p1 = tab_y[seg];
			p2 = tab_y[seg+1];
			p3 = tab_y[i3];
			// horner form, each product floored
			acc = -p0 + 3 * p1 - 3 * p2 + p3;
			acc = (2 * p0 - 5 * p1 + 4 * p2 - p3) + ((acc * u) >>> FracBits);
			acc = (p2 - p0) + ((acc * u) >>> FracBits);
			acc = 2 * p1 + ((acc * u) >>> FracBits);
			if (acc <= 0)
				return '0;
			yv = (acc + 1) >> 1;
			return yv > 65535 ? 16'hFFFF : coord_t'(yv);
		endfunction

		function void note_item(logic o, logic [3:0] idx, coord_t x, coord_t y,
				coord_t t);
			if (o == OpWrite) begin
				tab_x[idx] = x;
				tab_y[idx] = y;
			end else begin
				expected_values = {expected_values, curve_at(t)};
			end
		endfunction

		function void check_value(coord_t v);
			coord_t e;
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected curve value %h", $time, v);
				errors++;
				return;
			end
			e = expected_values.pop_front();
			if (v !== e) begin
				$display("%0t: curve_value expected %h actual %h", $time, e, v);
				errors++;
			end
		endfunction
	endclass

	localparam int CycleLimit = 1000000;
	localparam int SettleCycles = 100;   // longer than one evaluate item
	localparam int HoldCycles = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [3:0]  point_index;
	logic [15:0] point_x;
	logic [15:0] point_y;
	logic [15:0] position;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] curve_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [4:0]  cfg_data;

	curve_scoreboard curve_sb;
	int  cycles;
	int  items_sent;
	bit  quiet;       // no idling on either side while set
	bit  hold_req;    // asks the receiver for one long hold-off
	int  hold_left;

	curve_spline_evaluator_top dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || $urandom_range(99) >= 14;
		end
	end

	// result items are sampled mid-cycle, where all signals are settled
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			curve_sb.check_value(curve_value);
	end

	// offer one item and hold it until accepted, then maybe idle
	task automatic send_item(logic o, logic [3:0] idx, coord_t x, coord_t y, coord_t t);
		in_valid <= 1'b1;
		op <= o;
		point_index <= idx;
		point_x <= x;
		point_y <= y;
		position <= t;
		forever begin
			@(negedge clk);
			if (in_ready)
				break;
			@(posedge clk);
		end
		curve_sb.note_item(o, idx, x, y, t);
		items_sent++;
		@(posedge clk);
		if (!quiet && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic write_point(int idx, int x, int y);
		send_item(OpWrite, idx[3:0], x[15:0], y[15:0], coord_t'($urandom));
	endtask

	task automatic eval_at(int t);
		send_item(OpEval, 4'($urandom), 16'($urandom), 16'($urandom), t[15:0]);
	endtask

	// stop offering, wait for every expected item, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (curve_sb.expected_values.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// only called while the block is idle
	task automatic write_register(logic idx, int data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[4:0];
		forever begin
			@(negedge clk);
			if (cfg_ready)
				break;
			@(posedge clk);
		end
		curve_sb.set_register(idx, data[4:0]);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one random phase: registers, a table (mostly sorted), then evaluations
	task automatic random_phase(int phase);
		int n, cnt, x, nev;
		int xs [MaxPoints];
		drain();
		write_register(CfgSmoothMode, $urandom_range(1));
		// mostly legal counts, sometimes values that clamp
		cnt = $urandom_range(99) < 75 ? $urandom_range(2, MaxPoints) : $urandom_range(31);
		write_register(CfgPointCount, cnt);
		n = cnt < 2 ? 2 : (cnt > MaxPoints ? MaxPoints : cnt);
		x = 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 8)
				xs[i] = $urandom_range(65535);             // breaks the order
			else if (i > 0 && $urandom_range(99) < 10)
				xs[i] = x;                                 // zero-width segment
			else
				xs[i] = x + $urandom_range((65535 - x) * 2 / (n - i + 1));
			x = xs[i] > x ? xs[i] : x;
		end
		if ($urandom_range(3) == 0)
			xs[n-1] = 65535;
		for (int i = 0; i < n; i++)
			write_point(i, xs[i], $urandom_range(99) < 10 ?
				($urandom_range(1) ? 65535 : 0) : $urandom_range(65535));
		// occasional stray write to a slot beyond the count
		if (n < MaxPoints && $urandom_range(3) == 0)
			write_point($urandom_range(n, MaxPoints - 1), $urandom, $urandom);
		nev = $urandom_range(40, 90);
		for (int k = 0; k < nev; k++) begin
			if (phase == 3 && k == 10)
				hold_req = 1'b1;          // block fills and stalls its input
			if (phase == 6 && k == 20) begin
				in_valid <= 1'b0;         // sender waits for every result
				while (curve_sb.expected_values.size() != 0)
					@(posedge clk);
			end
			case ($urandom_range(9))
				0: eval_at(xs[$urandom_range(n - 1)]);
				1: eval_at(xs[$urandom_range(n - 1)] + 1);
				2: eval_at($urandom_range(1) ? 65535 : 0);
				default: eval_at($urandom_range(65535));
			endcase
		end
	endtask

	initial begin
		int phase;
		curve_sb = new();
		curve_sb.clear();
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OpWrite;
		point_index = '0;
		point_x = '0;
		point_y = '0;
		position = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CfgSmoothMode;
		cfg_data = '0;
		cycles = 0;
		items_sent = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset table, linear: ends and middle
		eval_at(0);
		eval_at(32768);
		eval_at(65535);
		drain();
		write_register(CfgSmoothMode, 1);
		eval_at(32768);
		// alternating ordinates make the cubic overshoot both ways
		write_point(0, 1000, 0);
		write_point(1, 20000, 65535);
		write_point(2, 20000, 0);
		write_point(3, 40000, 65535);
		write_point(15, 65535, 65535);
		drain();
		write_register(CfgPointCount, 4);
		eval_at(500);
		eval_at(1000);
		eval_at(10000);
		eval_at(20000);
		eval_at(30000);
		eval_at(40000);
		drain();
		write_register(CfgPointCount, 0);          // acts as two
		eval_at(5000);
		drain();
		write_register(CfgPointCount, 31);         // acts as sixteen
		write_register(CfgSmoothMode, 0);
		eval_at(30000);
		eval_at(65535);

		// random phases, one of them with no idling at all
		phase = 0;
		while (items_sent < 2000) begin
			quiet = (phase == 9);
			random_phase(phase);
			phase++;
		end
		quiet = 1'b0;
		drain();
		if (curve_sb.errors == 0 && curve_sb.expected_values.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
